>>> src/trs_pkg.sv
`default_nettype none

package trs_pkg;

   localparam int DEFAULT_ROWS_PER_PATTERN = 64;
   localparam int DEFAULT_ORDER_DEPTH      = 128;

   localparam int KIND_W     = 2;
   localparam int ORDER_W    = 7;
   localparam int PATTERN_W  = 7;
   localparam int ROW_W      = 6;
   localparam int TICK_W     = 5;
   localparam int DELAY_W    = 4;
   localparam int LENGTH_W   = 8;
   localparam int CSR_DATA_W = 8;
   localparam int CSR_INDEX_W = 1;

   localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_START = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_SONG_LENGTH   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INITIAL_SPEED = 1'd1;

   localparam logic [LENGTH_W-1:0] SONG_LENGTH_RESET   = 8'd1;
   localparam logic [TICK_W-1:0]   INITIAL_SPEED_RESET = 5'd6;
   localparam logic [TICK_W-1:0]   ROW_SPEED_RESET     = 5'd6;

   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic [ORDER_W-1:0]   table_index;
      logic [PATTERN_W-1:0] table_pattern;
      logic                 jump_request;
      logic [ORDER_W-1:0]   jump_target;
      logic                 break_request;
      logic [ROW_W-1:0]     break_row;
      logic [DELAY_W-1:0]   delay_rows;
      logic [TICK_W-1:0]    speed_request;
   } req_type;

   typedef struct packed {
      logic                 note_event;
      logic                 effect_event;
      logic [ORDER_W-1:0]   order_position;
      logic [PATTERN_W-1:0] pattern_number;
      logic [ROW_W-1:0]     row_number;
      logic [TICK_W-1:0]    tick_number;
      logic                 playing;
   } rsp_type;

endpackage

`default_nettype wire

>>> src/trs_order_mem.sv
`default_nettype none

module trs_order_mem #(
   parameter int ORDER_DEPTH = trs_pkg::DEFAULT_ORDER_DEPTH,
   localparam int ADDR_W = $clog2(ORDER_DEPTH)
) (
   input  wire logic                           clock,
   input  wire logic                           write_enable,
   input  wire logic [ADDR_W-1:0]              write_addr,
   input  wire logic [trs_pkg::PATTERN_W-1:0]  write_data,
   input  wire logic [ADDR_W-1:0]              succ_addr,
   input  wire logic [ADDR_W-1:0]              jump_addr,
   output logic      [trs_pkg::PATTERN_W-1:0]  succ_data,
   output logic      [trs_pkg::PATTERN_W-1:0]  jump_data
);
   import trs_pkg::*;

   logic [PATTERN_W-1:0] mem [ORDER_DEPTH];
   logic [PATTERN_W-1:0] succ_data_ff;
   logic [PATTERN_W-1:0] jump_data_ff;

   // read-during-write returns the new data
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_addr] <= write_data;
      end
      if (write_enable && (write_addr == succ_addr)) begin
         succ_data_ff <= write_data;
      end else begin
         succ_data_ff <= mem[succ_addr];
      end
      if (write_enable && (write_addr == jump_addr)) begin
         jump_data_ff <= write_data;
      end else begin
         jump_data_ff <= mem[jump_addr];
      end
   end

   assign succ_data = succ_data_ff;
   assign jump_data = jump_data_ff;

endmodule

`default_nettype wire

>>> src/tracker_row_sequencer.sv
// An accepted item sits in the input register, then its result in the output
// register. Throughput: one transaction per cycle unless stalled; the order
// table is read ahead (next order entry and jump target) through a two-port
// memory. Reset: synchronous, active high; clears handshake and playback
// state; the order table is not cleared and no clearing pass is run.
`default_nettype none

module tracker_row_sequencer #(
   parameter int ROWS_PER_PATTERN = trs_pkg::DEFAULT_ROWS_PER_PATTERN,
   parameter int ORDER_DEPTH      = trs_pkg::DEFAULT_ORDER_DEPTH
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire trs_pkg::req_type                 req_payload,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output trs_pkg::rsp_type                      rsp_payload,
   input  wire logic                             csr_write,
   input  wire logic [trs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [trs_pkg::CSR_DATA_W-1:0]   csr_data
);
   import trs_pkg::*;

   localparam int OIW  = $clog2(ORDER_DEPTH);
   localparam int RW   = $clog2(ROWS_PER_PATTERN);
   localparam int LW   = $clog2(ORDER_DEPTH + 1);
   localparam int CW   = (LW > LENGTH_W) ? LW : LENGTH_W;
   localparam int RCW  = ((RW + 1) > (ROW_W + 1)) ? (RW + 1) : (ROW_W + 1);

   // handshake and stage registers
   logic    req_valid_ff, req_valid_in;
   req_type req_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    advance, accept;
   req_type nxt_item;

   // configuration
   logic [LENGTH_W-1:0] song_length_ff;
   logic [TICK_W-1:0]   initial_speed_ff;

   // playback state
   logic [TICK_W-1:0]    tick_ff, tick_in;
   logic [TICK_W-1:0]    speed_ff, speed_in;
   logic [RW-1:0]        row_ff, row_in;
   logic [OIW-1:0]       order_ff, order_in;
   logic [PATTERN_W-1:0] pattern_ff, pattern_in;
   logic [DELAY_W-1:0]   delay_ff, delay_in;
   logic                 jp_ff, jp_in;
   logic [ORDER_W-1:0]   jd_ff, jd_in;
   logic                 bp_ff, bp_in;
   logic [ROW_W-1:0]     bd_ff, bd_in;
   logic                 running_ff, running_in;
   logic [PATTERN_W-1:0] entry0_ff;

   // tick datapath
   logic                 fetch, jp1, bp1, row_end, hold, last_order;
   logic                 jump_wrap, pattern_wrap, break_ok;
   logic [ORDER_W-1:0]   jd1;
   logic [ROW_W-1:0]     bd1;
   logic [DELAY_W-1:0]   dl1, dl2;
   logic [TICK_W-1:0]    spd1;
   logic [TICK_W:0]      tick_inc;
   logic [CW-1:0]        used_len;
   logic [RCW-1:0]       row_inc;
   logic [RW-1:0]        break_target;
   logic                 note, effect;

   // order table
   logic                 mem_we;
   logic [OIW-1:0]       succ_addr, jump_addr;
   logic [PATTERN_W-1:0] succ_data, jump_data;
   logic                 nxt_fetch;

   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign req_valid_in = accept || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   assign nxt_item  = accept ? req_payload : req_ff;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign used_len = (CW'(song_length_ff) > CW'(ORDER_DEPTH)) ? CW'(ORDER_DEPTH)
                                                             : CW'(song_length_ff);

   always_comb begin
      fetch    = (tick_ff == '0) && (delay_ff == '0);
      jp1      = jp_ff || (fetch && req_ff.jump_request);
      jd1      = (fetch && req_ff.jump_request) ? req_ff.jump_target : jd_ff;
      bp1      = bp_ff || (fetch && req_ff.break_request);
      bd1      = (fetch && req_ff.break_request) ? req_ff.break_row : bd_ff;
      dl1      = fetch ? req_ff.delay_rows : delay_ff;
      spd1     = (fetch && (req_ff.speed_request != '0)) ? req_ff.speed_request : speed_ff;
      tick_inc = {1'b0, tick_ff} + (TICK_W + 1)'(1);
      row_end  = tick_inc >= {1'b0, spd1};
      dl2      = (dl1 != '0) ? (dl1 - DELAY_W'(1)) : '0;
      hold     = (dl1 != '0) && (dl2 != '0);
      last_order   = (CW'(order_ff) + CW'(1)) >= used_len;
      jump_wrap    = CW'(jd1) >= used_len;
      row_inc      = RCW'(row_ff) + RCW'(1);
      pattern_wrap = row_inc >= RCW'(ROWS_PER_PATTERN);
      break_ok     = RCW'(bd1) < RCW'(ROWS_PER_PATTERN);
      break_target = break_ok ? RW'(bd1) : '0;
   end

   always_comb begin
      tick_in    = tick_ff;
      speed_in   = speed_ff;
      row_in     = row_ff;
      order_in   = order_ff;
      pattern_in = pattern_ff;
      delay_in   = delay_ff;
      jp_in      = jp_ff;
      jd_in      = jd_ff;
      bp_in      = bp_ff;
      bd_in      = bd_ff;
      running_in = running_ff;
      note       = 1'b0;
      effect     = 1'b0;
      if (advance) begin
         case (req_ff.kind)
            KIND_START: begin
               running_in = 1'b1;
               tick_in    = '0;
               row_in     = '0;
               order_in   = '0;
               delay_in   = '0;
               jp_in      = 1'b0;
               bp_in      = 1'b0;
               speed_in   = (initial_speed_ff == '0) ? TICK_W'(1) : initial_speed_ff;
               pattern_in = entry0_ff;
            end
            KIND_TICK: begin
               if (running_ff) begin
                  note     = fetch;
                  effect   = (tick_ff != '0);
                  jp_in    = jp1;
                  jd_in    = jd1;
                  bp_in    = bp1;
                  bd_in    = bd1;
                  delay_in = dl1;
                  speed_in = spd1;
                  tick_in  = tick_inc[TICK_W-1:0];
                  if (row_end) begin
                     tick_in  = '0;
                     delay_in = dl2;
                     if (!hold) begin
                        if (jp1 || bp1) begin
                           jp_in = 1'b0;
                           bp_in = 1'b0;
                           if (jp1) begin
                              order_in   = jump_wrap ? '0 : OIW'(jd1);
                              pattern_in = jump_wrap ? entry0_ff : jump_data;
                              row_in     = bp1 ? break_target : '0;
                           end else if (last_order) begin
                              running_in = 1'b0;
                              row_in     = '0;
                           end else begin
                              order_in   = order_ff + OIW'(1);
                              pattern_in = succ_data;
                              row_in     = break_target;
                           end
                        end else if (pattern_wrap) begin
                           row_in = '0;
                           if (last_order) begin
                              running_in = 1'b0;
                           end else begin
                              order_in   = order_ff + OIW'(1);
                              pattern_in = succ_data;
                           end
                        end else begin
                           row_in = RW'(row_inc);
                        end
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // result: load and start show the position after the item
   always_comb begin
      rsp_in.note_event   = note;
      rsp_in.effect_event = effect;
      rsp_in.playing      = running_in;
      if (req_ff.kind == KIND_TICK) begin
         rsp_in.order_position = ORDER_W'(order_ff);
         rsp_in.pattern_number = pattern_ff;
         rsp_in.row_number     = ROW_W'(row_ff);
         rsp_in.tick_number    = tick_ff;
      end else begin
         rsp_in.order_position = ORDER_W'(order_in);
         rsp_in.pattern_number = pattern_in;
         rsp_in.row_number     = ROW_W'(row_in);
         rsp_in.tick_number    = tick_in;
      end
   end

   // prefetch for the item that sits in the input register next cycle
   always_comb begin
      mem_we    = advance && (req_ff.kind == KIND_LOAD)
                  && (CW'(req_ff.table_index) < CW'(ORDER_DEPTH));
      nxt_fetch = (nxt_item.kind == KIND_TICK) && nxt_item.jump_request && running_in
                  && (tick_in == '0) && (delay_in == '0);
      succ_addr = order_in + OIW'(1);
      jump_addr = nxt_fetch ? OIW'(nxt_item.jump_target) : OIW'(jd_in);
   end

   trs_order_mem #(
      .ORDER_DEPTH (ORDER_DEPTH)
   ) u_order_mem (
      .clock        (clock),
      .write_enable (mem_we),
      .write_addr   (OIW'(req_ff.table_index)),
      .write_data   (req_ff.table_pattern),
      .succ_addr    (succ_addr),
      .jump_addr    (jump_addr),
      .succ_data    (succ_data),
      .jump_data    (jump_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         song_length_ff   <= SONG_LENGTH_RESET;
         initial_speed_ff <= INITIAL_SPEED_RESET;
         tick_ff          <= '0;
         speed_ff         <= ROW_SPEED_RESET;
         row_ff           <= '0;
         order_ff         <= '0;
         pattern_ff       <= '0;
         delay_ff         <= '0;
         jp_ff            <= 1'b0;
         jd_ff            <= '0;
         bp_ff            <= 1'b0;
         bd_ff            <= '0;
         running_ff       <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            case (csr_index)
               CSR_SONG_LENGTH:   song_length_ff   <= csr_data;
               CSR_INITIAL_SPEED: initial_speed_ff <= csr_data[TICK_W-1:0];
               default: begin
               end
            endcase
         end
         tick_ff    <= tick_in;
         speed_ff   <= speed_in;
         row_ff     <= row_in;
         order_ff   <= order_in;
         pattern_ff <= pattern_in;
         delay_ff   <= delay_in;
         jp_ff      <= jp_in;
         jd_ff      <= jd_in;
         bp_ff      <= bp_in;
         bd_ff      <= bd_in;
         running_ff <= running_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_payload;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
      if (mem_we && (req_ff.table_index == '0)) begin
         entry0_ff <= req_ff.table_pattern;
      end
   end

`ifndef SYNTHESIS
   a_tick_below_speed: assert property (@(posedge clock) disable iff (reset)
      tick_ff < speed_ff)
      else $error("tick counter reached row speed");

   a_row_in_pattern: assert property (@(posedge clock) disable iff (reset)
      RCW'(row_ff) < RCW'(ROWS_PER_PATTERN))
      else $error("row index past pattern end");

   a_one_event_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.note_event && rsp_ff.effect_event))
      else $error("note and effect event on the same tick");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed transaction produced no result");
`endif

endmodule

`default_nettype wire
